@@ design/fraction_sum_accumulator_assert.svh @@
// Assertion macros shared by the fraction sum accumulator modules.
// FSA_ASSERT checks a property at every clock edge outside reset.
// FSA_ASSERT_NEXT checks that a property holds in the cycle after a trigger.
`ifndef FRACTION_SUM_ACCUMULATOR_ASSERT_SVH
`define FRACTION_SUM_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fraction_sum_accumulator: assertion failed");
`define FSA_ASSERT_NEXT(lbl, clk, rst_n, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("fraction_sum_accumulator: assertion failed");
`else
`define FSA_ASSERT(lbl, clk, rst_n, prop)
`define FSA_ASSERT_NEXT(lbl, clk, rst_n, trig, prop)
`endif
`endif

@@ design/fsa_pkg.sv @@
`default_nettype none

package fsa_pkg;

    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int DEFAULT_WIDTH = 32;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_GCD = 2'd2;

    typedef enum logic [1:0] {
        MUL_P1,
        MUL_P2,
        MUL_DP
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_GCD,
        DIV_QN,
        DIV_QD
    } t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum_en;
        logic     mag_en;
        logic     gcd_init;
        logic     div_start;
        t_div_sel div_sel;
        logic     gcd_step;
        logic     qn_load;
        logic     qd_load;
        logic     out_commit;
    } t_dp_cmd;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ design/fsa_stream_if.sv @@
`default_nettype none

interface fsa_in_if import fsa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] frac_num;
    logic [DATA_W-1:0] frac_den;
    logic              end_of_set;

    modport source (output valid, output frac_num, output frac_den, output end_of_set,
                    input ready);
    modport sink (input valid, input frac_num, input frac_den, input end_of_set,
                  output ready);
endinterface

interface fsa_out_if import fsa_pkg::*;;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   sum_num;
    logic [DATA_W-1:0]   sum_den;
    logic [STATUS_W-1:0] status;
    logic                is_final;

    modport source (output valid, output sum_num, output sum_den, output status,
                    output is_final, input ready);
    modport sink (input valid, input sum_num, input sum_den, input status,
                  input is_final, output ready);
endinterface

`default_nettype wire

@@ design/fsa_divider.sv @@
`default_nettype none
`include "fraction_sum_accumulator_assert.svh"

// Restoring unsigned divider, one quotient bit per cycle.
module fsa_divider import fsa_pkg::*; #(
    parameter int DIV_W = 2 * DEFAULT_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quotient,
    output logic      [DIV_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `FSA_ASSERT(a_div_no_restart, i_clk, i_rst_n, i_start |-> !r_busy)
    `FSA_ASSERT(a_div_nonzero, i_clk, i_rst_n, r_busy |-> (r_dvs != '0))
    `FSA_ASSERT_NEXT(a_div_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy)

endmodule

`default_nettype wire

@@ design/fsa_datapath.sv @@
`default_nettype none
`include "fraction_sum_accumulator_assert.svh"

module fsa_datapath import fsa_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [DATA_W-1:0]   i_frac_num,
    input  wire logic [DATA_W-1:0]   i_frac_den,
    input  wire logic                i_end_of_set,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [DATA_W-1:0]   o_sum_num,
    output logic      [DATA_W-1:0]   o_sum_den,
    output logic      [STATUS_W-1:0] o_status,
    output logic                     o_is_final
);

    localparam int P   = 2 * WIDTH;
    localparam int P1W = P + 1;
    localparam logic [P-1:0] HALF = P'(1) << (WIDTH - 1);

    logic signed [WIDTH-1:0] r_acc_num;
    logic signed [WIDTH-1:0] r_acc_den;
    logic signed [WIDTH-1:0] r_bn;
    logic signed [WIDTH-1:0] r_bd;
    logic                    r_last;
    logic signed [P-1:0]     r_p1;
    logic signed [P-1:0]     r_p2;
    logic signed [P-1:0]     r_dp;
    logic signed [P:0]       r_sum;
    logic        [P-1:0]     r_nmag;
    logic        [P-1:0]     r_dmag;
    logic                    r_nneg;
    logic                    r_dneg;
    logic        [P-1:0]     r_a;
    logic        [P-1:0]     r_b;
    logic                    r_par;
    logic        [P-1:0]     r_qn;
    logic        [P-1:0]     r_qd;

    logic                    r_out_valid;
    logic        [DATA_W-1:0]   r_out_num;
    logic        [DATA_W-1:0]   r_out_den;
    logic        [STATUS_W-1:0] r_out_status;
    logic                    r_out_final;

    logic signed [WIDTH-1:0] w_mul_x;
    logic signed [WIDTH-1:0] w_mul_y;
    logic signed [P-1:0]     w_prod;
    logic        [P:0]       w_nabs;
    logic        [P-1:0]     w_dabs;
    logic        [P-1:0]     w_dividend;
    logic        [P-1:0]     w_divisor;
    logic                    w_div_done;
    logic        [P-1:0]     w_quo;
    logic        [P-1:0]     w_rem;
    logic                    w_gneg;
    logic                    w_qnneg;
    logic                    w_qdneg;
    logic                    w_fit;
    logic signed [WIDTH-1:0] w_qn_lo;
    logic signed [WIDTH-1:0] w_qd_lo;
    logic signed [WIDTH-1:0] n_acc_num;
    logic signed [WIDTH-1:0] n_acc_den;
    logic        [STATUS_W-1:0] n_status;

    // One shared multiplier, three passes per item.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_P1: begin
                w_mul_x = r_acc_num;
                w_mul_y = r_bd;
            end
            MUL_P2: begin
                w_mul_x = r_bn;
                w_mul_y = r_acc_den;
            end
            default: begin
                w_mul_x = r_acc_den;
                w_mul_y = r_bd;
            end
        endcase
    end

    assign w_prod = w_mul_x * w_mul_y;
    assign w_nabs = r_sum[P] ? -r_sum : r_sum;
    assign w_dabs = r_dp[P-1] ? -r_dp : r_dp;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_QN: begin
                w_dividend = r_nmag;
                w_divisor  = r_a;
            end
            DIV_QD: begin
                w_dividend = r_dmag;
                w_divisor  = r_a;
            end
            default: begin
                w_dividend = r_a;
                w_divisor  = r_b;
            end
        endcase
    end

    fsa_divider #(
        .DIV_W(P)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Sign of the gcd follows the operand that ended the Euclid loop.
    assign w_gneg  = r_par ? r_dneg : r_nneg;
    assign w_qnneg = (r_qn != '0) && (r_nneg != w_gneg);
    assign w_qdneg = (r_qd != '0) && (r_dneg != w_gneg);
    assign w_fit   = (w_qnneg ? (r_qn <= HALF) : (r_qn < HALF)) &&
                     (w_qdneg ? (r_qd <= HALF) : (r_qd < HALF));
    assign w_qn_lo = r_qn[WIDTH-1:0];
    assign w_qd_lo = r_qd[WIDTH-1:0];

    always_comb begin
        n_acc_num = r_acc_num;
        n_acc_den = r_acc_den;
        if (r_a == '0) begin
            n_status = STATUS_ZERO_GCD;
        end else if (!w_fit) begin
            n_status = STATUS_OVERFLOW;
        end else begin
            n_status  = STATUS_OK;
            n_acc_num = w_qnneg ? ('0 - w_qn_lo) : w_qn_lo;
            n_acc_den = w_qdneg ? ('0 - w_qd_lo) : w_qd_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_num   <= '0;
            r_acc_den   <= WIDTH'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_commit) begin
                r_out_valid <= 1'b1;
                r_acc_num   <= r_last ? '0 : n_acc_num;
                r_acc_den   <= r_last ? WIDTH'(1) : n_acc_den;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_bn   <= i_frac_num[WIDTH-1:0];
            r_bd   <= i_frac_den[WIDTH-1:0];
            r_last <= i_end_of_set;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_P1:  r_p1 <= w_prod;
                MUL_P2:  r_p2 <= w_prod;
                default: r_dp <= w_prod;
            endcase
        end
        if (i_cmd.sum_en) begin
            r_sum <= P1W'(r_p1) + P1W'(r_p2);
        end
        if (i_cmd.mag_en) begin
            r_nmag <= w_nabs[P-1:0];
            r_nneg <= r_sum[P];
            r_dmag <= w_dabs;
            r_dneg <= r_dp[P-1];
        end
        if (i_cmd.gcd_init) begin
            r_a   <= r_nmag;
            r_b   <= r_dmag;
            r_par <= 1'b0;
        end else if (i_cmd.gcd_step) begin
            r_a   <= r_b;
            r_b   <= w_rem;
            r_par <= ~r_par;
        end
        if (i_cmd.qn_load) begin
            r_qn <= w_quo;
        end
        if (i_cmd.qd_load) begin
            r_qd <= w_quo;
        end
        if (i_cmd.out_commit) begin
            r_out_num    <= DATA_W'(n_acc_num);
            r_out_den    <= DATA_W'(n_acc_den);
            r_out_status <= n_status;
            r_out_final  <= r_last;
        end
    end

    assign o_sts.a_zero   = (r_a == '0);
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_sum_num   = r_out_num;
    assign o_sum_den   = r_out_den;
    assign o_status    = r_out_status;
    assign o_is_final  = r_out_final;

    `FSA_ASSERT(a_dp_no_overwrite, i_clk, i_rst_n,
                i_cmd.out_commit |-> !(r_out_valid && !i_out_ready))

endmodule

`default_nettype wire

@@ design/fsa_ctrl.sv @@
`default_nettype none
`include "fraction_sum_accumulator_assert.svh"

module fsa_ctrl import fsa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P1,
        S_MUL_P2,
        S_MUL_DP,
        S_SUM,
        S_MAG,
        S_INIT,
        S_TEST,
        S_GCD_GO,
        S_GCD_WAIT,
        S_QN_GO,
        S_QN_WAIT,
        S_QD_GO,
        S_QD_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;
    logic   w_accept;

    assign w_accept = i_in_valid && r_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_P1;
        o_cmd.div_sel = DIV_GCD;
        n_state       = r_state;
        n_ready       = r_ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    n_ready       = 1'b0;
                    n_state       = S_MUL_P1;
                end
            end
            S_MUL_P1: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_MUL_P2;
            end
            S_MUL_P2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P2;
                n_state       = S_MUL_DP;
            end
            S_MUL_DP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DP;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag_en = 1'b1;
                n_state      = S_INIT;
            end
            S_INIT: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = S_TEST;
            end
            S_TEST: begin
                if (!i_sts.b_zero) begin
                    n_state = S_GCD_GO;
                end else if (i_sts.a_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_QN_GO;
                end
            end
            S_GCD_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_GCD_WAIT;
            end
            S_GCD_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.gcd_step = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_QN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_QN;
                n_state         = S_QN_WAIT;
            end
            S_QN_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.qn_load = 1'b1;
                    n_state       = S_QD_GO;
                end
            end
            S_QD_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_QD;
                n_state         = S_QD_WAIT;
            end
            S_QD_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.qd_load = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_commit = 1'b1;
                    n_ready          = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

    `FSA_ASSERT(a_ctrl_ready_idle, i_clk, i_rst_n, r_ready |-> (r_state == S_IDLE))

endmodule

`default_nettype wire

@@ design/fraction_sum_accumulator.sv @@
// Fraction sum accumulator. Each input beat carries one signed fraction
// (frac_num / frac_den, of which the low WIDTH bits are used as two's
// complement) that is added to a running sum starting at 0/1. The new sum is
// formed at full precision as acc_num*frac_den + frac_num*acc_den over
// acc_den*frac_den and reduced by Euclid's algorithm with truncating
// remainders, so the signs of the result follow C integer division. Every
// input beat produces exactly one output beat carrying the running sum,
// sign-extended to 32 bits. When the reduced sum does not fit in WIDTH bits
// the old sum is kept and status reports an overflow; when numerator and
// denominator are both zero the old sum is kept and status reports a zero
// gcd. An input beat with end_of_set set returns its result with is_final
// set, and the sum restarts at 0/1 afterwards. The block works on one item
// at a time: one shared multiplier forms the three products one after
// another, and a single restoring divider of 2*WIDTH bits, retiring one
// quotient bit per cycle, does every Euclid remainder step and the two final
// quotient divisions. The number of Euclid remainder steps is zero when the
// new denominator is zero and at most about 1.44 * 2*WIDTH. A zero gcd
// skips both quotient divisions. The result sits in an output register, so
// the next input beat is taken while the previous result still waits for
// its consumer; a result that is still waiting holds the commit of the
// following one.
`default_nettype none

module fraction_sum_accumulator import fsa_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fsa_in_if.sink     i_frac,
    fsa_out_if.source  o_sum
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // Sequencing: accept, multiply, sum, Euclid loop, quotients, commit.
    fsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_frac.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, running sum and the output register.
    fsa_datapath #(
        .WIDTH(WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_frac_num   (i_frac.frac_num),
        .i_frac_den   (i_frac.frac_den),
        .i_end_of_set (i_frac.end_of_set),
        .o_out_valid  (o_sum.valid),
        .i_out_ready  (o_sum.ready),
        .o_sum_num    (o_sum.sum_num),
        .o_sum_den    (o_sum.sum_den),
        .o_status     (o_sum.status),
        .o_is_final   (o_sum.is_final)
    );

    assign i_frac.ready = w_in_ready;

endmodule

`default_nettype wire
